// ===== rtl/core/idea_pkg.sv =====
// Shared constants, types and a helper function for the IDEA cipher core.
package idea_pkg;

  localparam int unsigned IDEA_ROUNDS    = 8;
  localparam int unsigned IDEA_ROW_COUNT = 9;
  localparam int unsigned IDEA_MEM_DEPTH = 2 * IDEA_ROW_COUNT;
  localparam int unsigned IDEA_INV_STEPS = 30;

  localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [1:0] CFG_KEY_LOW  = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_ENC,
    ST_KEY_DEC,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } idea_state_e;

  typedef enum logic [1:0] {
    OP_COPY,
    OP_NEG,
    OP_INV
  } idea_op_e;

  // Encryption subkey idx: word idx%8 of the key rotated left by 25*(idx/8)
  function automatic logic [15:0] enc_subkey(input logic [127:0] key, input logic [5:0] idx);
    logic [8:0]   sum;
    logic [6:0]   sh;
    logic [255:0] dbl;
    sum = 9'({idx[5:3], 4'b0}) + 9'({idx[5:3], 3'b0}) + 9'(idx[5:3]) + 9'({idx[2:0], 4'b0});
    sh  = sum[6:0];
    dbl = {key, key} << sh;
    return dbl[255:240];
  endfunction

endpackage

// ===== rtl/core/idea_block_cipher_unit.sv =====
// IDEA cipher core: key schedule sequencer, subkey row memory and round sequencer.
// A block is worked through after acceptance and its result is then presented until taken;
// a new block is taken only once the last result has gone. The one modulo-65537 multiplier,
// used four times per round and twice in the output transform, sets the pace. After a key register write
// the block computes the schedule (52 encryption subkeys at one a cycle, then
// 52 decryption subkeys, each inverse taking 30 multiplies) and takes no request meanwhile.
// Before any key write a request returns zero.
module idea_block_cipher_unit #(
  parameter int unsigned ROUNDS = idea_pkg::IDEA_ROUNDS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [63:0] data_block
  input  logic        s_axis_tuser,  // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // [63:0] result_block
);

  localparam int unsigned AW = $clog2(idea_pkg::IDEA_MEM_DEPTH);
  localparam logic [2:0] LAST_RND = 3'(ROUNDS - 1);
  localparam logic [3:0] FIN_ROW  = 4'(idea_pkg::IDEA_ROW_COUNT - 1);
  localparam logic [4:0] INV_LAST = 5'(idea_pkg::IDEA_INV_STEPS - 1);

  idea_pkg::idea_state_e state_q, state_d;

  logic [127:0] key_q, key_d;
  logic         ready_q, ready_d;
  logic [3:0]   ks_row_q, ks_row_d;
  logic [2:0]   ks_pos_q, ks_pos_d;
  logic [4:0]   inv_cnt_q, inv_cnt_d;
  logic [15:0]  inv_q, inv_d;
  logic [95:0]  row_q, row_d;
  logic [2:0]   rnd_q, rnd_d;
  logic [1:0]   ph_q, ph_d;
  logic         dec_q, dec_d;
  logic [15:0]  x1_q, x1_d, x2_q, x2_d, x3_q, x3_d, x4_q, x4_d, t_q, t_d;
  logic [63:0]  res_q, res_d;

  logic [95:0]  mem_q [idea_pkg::IDEA_MEM_DEPTH];
  logic [95:0]  rd_q;
  logic         rd_en;
  logic [AW-1:0] rd_addr;
  logic         wr_en;
  logic [AW-1:0] wr_addr;
  logic [95:0]  wr_row;

  logic [15:0]  mul_a, mul_b, mul_p;
  logic [5:0]   six_r;
  logic [5:0]   src_idx;
  logic [15:0]  src_key;
  idea_pkg::idea_op_e op;
  logic         swap;
  logic [15:0]  commit_val;
  logic         commit;
  logic         row_end;
  logic [15:0]  s0, s1, s2, s3, s4, s5;
  logic [15:0]  x3n;
  logic [AW-1:0] base;

  idea_mmul u_mmul (
    .a_i(mul_a),
    .b_i(mul_b),
    .p_o(mul_p)
  );

  assign s0 = rd_q[15:0];
  assign s1 = rd_q[31:16];
  assign s2 = rd_q[47:32];
  assign s3 = rd_q[63:48];
  assign s4 = rd_q[79:64];
  assign s5 = rd_q[95:80];

  assign six_r = 6'({ks_row_q, 2'b00}) + 6'({ks_row_q, 1'b0});
  assign swap  = (ks_row_q != 4'd0) && (ks_row_q != FIN_ROW);
  assign src_key = idea_pkg::enc_subkey(key_q, src_idx);
  assign row_end = (ks_pos_q == 3'd5) || ((ks_row_q == FIN_ROW) && (ks_pos_q == 3'd3));
  assign base = dec_q ? AW'(idea_pkg::IDEA_ROW_COUNT) : '0;

  always_comb begin
    src_idx = six_r + 6'(ks_pos_q);
    op      = idea_pkg::OP_COPY;
    if (state_q == idea_pkg::ST_KEY_DEC) begin
      case (ks_pos_q)
        3'd0: begin
          src_idx = 6'd48 - six_r;
          op      = idea_pkg::OP_INV;
        end
        3'd1: begin
          src_idx = swap ? 6'd50 - six_r : 6'd49 - six_r;
          op      = idea_pkg::OP_NEG;
        end
        3'd2: begin
          src_idx = swap ? 6'd49 - six_r : 6'd50 - six_r;
          op      = idea_pkg::OP_NEG;
        end
        3'd3: begin
          src_idx = 6'd51 - six_r;
          op      = idea_pkg::OP_INV;
        end
        3'd4: src_idx = 6'd46 - six_r;
        default: src_idx = 6'd47 - six_r;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    ready_d   = ready_q;
    ks_row_d  = ks_row_q;
    ks_pos_d  = ks_pos_q;
    inv_cnt_d = inv_cnt_q;
    inv_d     = inv_q;
    row_d     = row_q;
    rnd_d     = rnd_q;
    ph_d      = ph_q;
    dec_d     = dec_q;
    x1_d      = x1_q;
    x2_d      = x2_q;
    x3_d      = x3_q;
    x4_d      = x4_q;
    t_d       = t_q;
    res_d     = res_q;
    rd_en     = 1'b0;
    rd_addr   = base;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_row    = row_q;
    mul_a     = x1_q;
    mul_b     = s0;
    x3n       = '0;
    commit    = 1'b0;
    commit_val = src_key;

    s_axis_tready = (state_q == idea_pkg::ST_IDLE) && !cfg_we_i;
    m_axis_tvalid = (state_q == idea_pkg::ST_OUT);

    case (state_q)
      idea_pkg::ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          dec_d   = s_axis_tuser;
          x1_d    = s_axis_tdata[63:48];
          x2_d    = s_axis_tdata[47:32];
          x3_d    = s_axis_tdata[31:16];
          x4_d    = s_axis_tdata[15:0];
          rnd_d   = '0;
          ph_d    = '0;
          rd_en   = 1'b1;
          rd_addr = s_axis_tuser ? AW'(idea_pkg::IDEA_ROW_COUNT) : '0;
          if (ready_q) begin
            state_d = idea_pkg::ST_ROUND;
          end else begin
            res_d   = '0;
            state_d = idea_pkg::ST_OUT;
          end
        end
      end
      idea_pkg::ST_KEY_ENC: begin
        commit = 1'b1;
      end
      idea_pkg::ST_KEY_DEC: begin
        case (op)
          idea_pkg::OP_NEG: begin
            commit     = 1'b1;
            commit_val = (~src_key) + 16'd1;
          end
          idea_pkg::OP_INV: begin
            mul_a      = (inv_cnt_q == 5'd0) ? src_key : inv_q;
            mul_b      = inv_cnt_q[0] ? src_key : mul_a;
            inv_d      = mul_p;
            commit_val = mul_p;
            if (inv_cnt_q == INV_LAST) begin
              commit    = 1'b1;
              inv_cnt_d = '0;
            end else begin
              inv_cnt_d = inv_cnt_q + 5'd1;
            end
          end
          default: commit = 1'b1;
        endcase
      end
      idea_pkg::ST_ROUND: begin
        ph_d = ph_q + 2'd1;
        case (ph_q)
          2'd0: begin
            mul_a = x1_q;
            mul_b = s0;
            x1_d  = mul_p;
            x2_d  = x2_q + s1;
            x3_d  = x3_q + s2;
          end
          2'd1: begin
            mul_a = x4_q;
            mul_b = s3;
            x4_d  = mul_p;
          end
          2'd2: begin
            mul_a = x3_q ^ x1_q;
            mul_b = s4;
            t_d   = mul_p;
          end
          default: begin
            mul_a = (x2_q ^ x4_q) + t_q;
            mul_b = s5;
            x3n   = t_q + mul_p;
            x1_d  = x1_q ^ mul_p;
            x4_d  = x4_q ^ x3n;
            x2_d  = mul_p ^ x3_q;
            x3_d  = x3n ^ x2_q;
            rd_en = 1'b1;
            if (rnd_q == LAST_RND) begin
              rd_addr = base + AW'(FIN_ROW);
              state_d = idea_pkg::ST_FINAL;
            end else begin
              rd_addr = base + AW'(rnd_q) + AW'(1);
              rnd_d   = rnd_q + 3'd1;
            end
          end
        endcase
      end
      idea_pkg::ST_FINAL: begin
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd0) begin
          mul_a = x1_q;
          mul_b = s0;
          x1_d  = mul_p;
          x2_d  = x2_q + s2;
          x3_d  = x3_q + s1;
        end else begin
          mul_a   = x4_q;
          mul_b   = s3;
          res_d   = {x1_q, x3_q, x2_q, mul_p};
          state_d = idea_pkg::ST_OUT;
        end
      end
      idea_pkg::ST_OUT: begin
        if (m_axis_tready) begin
          state_d = idea_pkg::ST_IDLE;
        end
      end
      default: state_d = idea_pkg::ST_IDLE;
    endcase

    if (commit) begin
      wr_row = row_q;
      wr_row[{ks_pos_q, 4'b0} +: 16] = commit_val;
      row_d  = wr_row;
      if (row_end) begin
        wr_en    = 1'b1;
        wr_addr  = (state_q == idea_pkg::ST_KEY_DEC) ?
                   AW'(idea_pkg::IDEA_ROW_COUNT) + AW'(ks_row_q) : AW'(ks_row_q);
        ks_pos_d = '0;
        ks_row_d = ks_row_q + 4'd1;
        if (ks_row_q == FIN_ROW) begin
          ks_row_d = '0;
          if (state_q == idea_pkg::ST_KEY_DEC) begin
            state_d = idea_pkg::ST_IDLE;
            ready_d = 1'b1;
          end else begin
            state_d = idea_pkg::ST_KEY_DEC;
          end
        end
      end else begin
        ks_pos_d = ks_pos_q + 3'd1;
      end
    end

    if (cfg_we_i && ((cfg_addr_i == idea_pkg::CFG_KEY_HIGH) ||
                     (cfg_addr_i == idea_pkg::CFG_KEY_LOW))) begin
      if (cfg_addr_i == idea_pkg::CFG_KEY_HIGH) begin
        key_d[127:64] = cfg_data_i;
      end else begin
        key_d[63:0] = cfg_data_i;
      end
      state_d   = idea_pkg::ST_KEY_ENC;
      ks_row_d  = '0;
      ks_pos_d  = '0;
      inv_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= idea_pkg::ST_IDLE;
      key_q     <= '0;
      ready_q   <= 1'b0;
      ks_row_q  <= '0;
      ks_pos_q  <= '0;
      inv_cnt_q <= '0;
      rnd_q     <= '0;
      ph_q      <= '0;
    end else begin
      state_q   <= state_d;
      key_q     <= key_d;
      ready_q   <= ready_d;
      ks_row_q  <= ks_row_d;
      ks_pos_q  <= ks_pos_d;
      inv_cnt_q <= inv_cnt_d;
      rnd_q     <= rnd_d;
      ph_q      <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inv_q <= inv_d;
    row_q <= row_d;
    dec_q <= dec_d;
    x1_q  <= x1_d;
    x2_q  <= x2_d;
    x3_q  <= x3_d;
    x4_q  <= x4_d;
    t_q   <= t_d;
    res_q <= res_d;
  end

  // subkey rows: encryption rows first, then decryption rows
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign m_axis_tdata = res_q;

  a_no_take_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request taken while a result waits");

  a_sched_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == idea_pkg::ST_KEY_ENC || state_q == idea_pkg::ST_KEY_DEC) |-> !s_axis_tready)
    else $error("request taken during key schedule");

  a_unkeyed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !ready_q) |=> (m_axis_tvalid && m_axis_tdata == 64'd0))
    else $error("unkeyed request did not return zero");

  a_inv_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inv_cnt_q <= INV_LAST)
    else $error("inverse step count overrun");

endmodule

// ===== rtl/core/idea_mmul.sv =====
// Multiplier modulo 65537 with the zero word standing for 65536.
module idea_mmul (
  input  logic [15:0] a_i,
  input  logic [15:0] b_i,
  output logic [15:0] p_o
);

  logic [31:0] prod;
  logic [15:0] hi;
  logic [15:0] lo;

  always_comb begin
    prod = 32'(a_i) * 32'(b_i);
    hi   = prod[31:16];
    lo   = prod[15:0];
    if (prod == 32'd0) begin
      p_o = 16'd1 - a_i - b_i;
    end else begin
      p_o = lo - hi + ((lo < hi) ? 16'd1 : 16'd0);
    end
  end

endmodule

// ===== verif/tb_idea_block_cipher_unit.sv =====
// Testbench for the IDEA cipher core: key schedules, encrypt and decrypt requests, random stalls.
`timescale 1ns / 1ps

class idea_scoreboard;
  logic [63:0] pending_blocks[$];
  int unsigned n_errors;
  int unsigned n_checked;

  function new();
    n_errors = 0;
    n_checked = 0;
  endfunction

  function void note_request(logic [63:0] expected_block);
    pending_blocks.push_back(expected_block);
  endfunction

  function void check_result(logic [63:0] actual_block);
    logic [63:0] exp_blk;
    if (pending_blocks.size() == 0) begin
      $error("unexpected result_block %h", actual_block);
      n_errors++;
      return;
    end
    exp_blk = pending_blocks.pop_front();
    n_checked++;
    if (exp_blk !== actual_block) begin
      $error("result_block expected %h actual %h", exp_blk, actual_block);
      n_errors++;
    end
  endfunction
endclass

module tb_idea_block_cipher_unit;

  localparam int unsigned NUM_RANDOM = 1440;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  idea_scoreboard sb = new();

  logic [63:0] key_hi_q, key_lo_q;
  logic [15:0] enc_keys[52];
  logic [15:0] dec_keys[52];
  bit          keyed;
  bit          sink_busy_mode;
  int unsigned n_enc, n_dec, n_keys;

  always #5 clk_i = ~clk_i;

  idea_block_cipher_unit u_top (.*);

  function automatic logic [15:0] mul_mod(logic [15:0] a, logic [15:0] b);
    logic [31:0] p, hi, lo;
    p = a * b;
    if (p == 0) return 16'(32'd1 - a - b);
    hi = p >> 16;
    lo = p & 32'hFFFF;
    return 16'(lo - hi + ((lo < hi) ? 1 : 0));
  endfunction

  function automatic logic [15:0] mul_inverse(logic [15:0] a);
    logic [15:0] r;
    r = a;
    for (int i = 0; i < 15; i++) begin
      r = mul_mod(r, r);
      r = mul_mod(r, a);
    end
    return r;
  endfunction

  task automatic build_schedule();
    logic [63:0] k0, k1, a, b;
    logic [15:0] t;
    k0 = key_hi_q;
    k1 = key_lo_q;
    for (int off = 0; off < 48; off += 8) begin
      for (int i = 0; i < 8; i++)
        enc_keys[off+i] = 16'((i < 4 ? k0 : k1) >> (48 - 16 * (i % 4)));
      a = k0 >> 39;
      b = k1 >> 39;
      k0 = (k0 << 25) | b;
      k1 = (k1 << 25) | a;
    end
    for (int i = 0; i < 4; i++) enc_keys[48+i] = 16'(k0 >> (48 - 16 * i));
    dec_keys[0] = mul_inverse(enc_keys[48]);
    dec_keys[1] = -enc_keys[49];
    dec_keys[2] = -enc_keys[50];
    dec_keys[3] = mul_inverse(enc_keys[51]);
    for (int i = 0; i < 48; i += 6) begin
      dec_keys[i+4] = enc_keys[46-i];
      dec_keys[i+5] = enc_keys[47-i];
      dec_keys[i+6] = mul_inverse(enc_keys[42-i]);
      dec_keys[i+7] = -enc_keys[44-i];
      dec_keys[i+8] = -enc_keys[43-i];
      dec_keys[i+9] = mul_inverse(enc_keys[45-i]);
    end
    t = dec_keys[49];
    dec_keys[49] = dec_keys[50];
    dec_keys[50] = t;
    keyed = 1'b1;
  endtask

  function automatic logic [63:0] cipher_block(logic [63:0] blk, bit decrypt);
    logic [15:0] x1, x2, x3, x4, t0, t1;
    logic [15:0] k[52];
    if (!keyed) return '0;
    for (int n = 0; n < 52; n++) begin
      if (decrypt) k[n] = dec_keys[n];
      else k[n] = enc_keys[n];
    end
    {x1, x2, x3, x4} = blk;
    for (int j = 0; j < idea_pkg::IDEA_ROUNDS; j++) begin
      x1 = mul_mod(x1, k[6*j]);
      x2 = x2 + k[6*j+1];
      x3 = x3 + k[6*j+2];
      x4 = mul_mod(x4, k[6*j+3]);
      t0 = x3;
      x3 = mul_mod(x3 ^ x1, k[6*j+4]);
      t1 = x2;
      x2 = mul_mod((x2 ^ x4) + x3, k[6*j+5]);
      x3 = x3 + x2;
      x1 ^= x2;
      x4 ^= x3;
      x2 ^= t0;
      x3 ^= t1;
    end
    x1 = mul_mod(x1, k[48]);
    x2 = x2 + k[50];
    x3 = x3 + k[49];
    x4 = mul_mod(x4, k[51]);
    return {x1, x3, x2, x4};
  endfunction

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  task automatic wait_drained();
    while (sb.pending_blocks.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_key(logic [1:0] idx, logic [63:0] val);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == idea_pkg::CFG_KEY_HIGH) key_hi_q = val;
    else key_lo_q = val;
    build_schedule();
    n_keys++;
  endtask

  task automatic send_request(bit decrypt, logic [63:0] blk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= decrypt;
    s_axis_tdata <= blk;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(cipher_block(blk, decrypt));
    if (decrypt) n_dec++;
    else n_enc++;
    begin
      int unsigned g;
      g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (g != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] edge_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {4{16'h0001}};
      3: return {4{16'h8000}};
      default: return rand64();
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (!sink_busy_mode) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
  end

  initial begin
    sink_busy_mode = 1'b0;
    forever begin
      repeat ($urandom_range(50, 400)) @(posedge clk_i);
      sink_busy_mode = ~sink_busy_mode;
    end
  end

  initial begin
    #100ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [63:0] pt;
    keyed = 1'b0;
    key_hi_q = '0;
    key_lo_q = '0;
    n_enc = 0;
    n_dec = 0;
    n_keys = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no key yet: zero result
    send_request(1'b0, '1);
    send_request(1'b1, 64'h0123_4567_89AB_CDEF);
    end_burst();
    // only the high half written
    write_key(idea_pkg::CFG_KEY_HIGH, 64'h0001_0002_0003_0004);
    send_request(1'b0, 64'h0000_0001_0002_0003);
    send_request(1'b1, '0);
    end_burst();
    write_key(idea_pkg::CFG_KEY_LOW, 64'h0005_0006_0007_0008);
    send_request(1'b0, 64'h0000_0001_0002_0003);
    send_request(1'b1, 64'h11FB_ED2B_0198_6DE5);
    send_request(1'b0, '0);
    send_request(1'b0, '1);
    send_request(1'b1, {4{16'h8000}});
    end_burst();
    // out-of-range index must be ignored
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_addr_i <= 2'd2;
    cfg_data_i <= '1;
    @(posedge clk_i);
    cfg_addr_i <= 2'd3;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (5) @(posedge clk_i);
    send_request(1'b0, 64'h0000_0001_0002_0003);
    end_burst();
    write_key(idea_pkg::CFG_KEY_HIGH, '1);
    write_key(idea_pkg::CFG_KEY_LOW, '1);
    send_request(1'b0, '0);
    send_request(1'b1, '1);
    end_burst();
    write_key(idea_pkg::CFG_KEY_HIGH, '0);
    write_key(idea_pkg::CFG_KEY_LOW, '0);
    send_request(1'b0, '1);
    send_request(1'b1, '0);
    end_burst();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 150 == 0) begin
        end_burst();
        write_key($urandom_range(0, 3) == 0 ? idea_pkg::CFG_KEY_HIGH : idea_pkg::CFG_KEY_LOW,
                  edge_word());
        if ($urandom_range(0, 1)) write_key(idea_pkg::CFG_KEY_HIGH, rand64());
      end
      if (i % 97 == 50) begin
        end_burst();
        wait_drained();
      end
      pt = ($urandom_range(0, 7) == 0) ? edge_word() : rand64();
      send_request($urandom_range(0, 1), pt);
      // round trip: decrypt the encryption of the same block pt
      if ($urandom_range(0, 3) == 0) send_request(1'b1, cipher_block(pt, 1'b0));
    end
    end_burst();

    wait_drained();
    $display("covered %0d encrypt and %0d decrypt requests under %0d key writes",
             n_enc, n_dec, n_keys);
    $display("checked %0d results with random stalls on both sides", sb.n_checked);
    if (sb.n_errors == 0 && sb.pending_blocks.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
